// ===== hdl/vgd_pkg.sv =====
// ----------------------------------------------------------------------------
// vgd_pkg
// Shared types and constants of the voxel grid point deduplicator.
// ----------------------------------------------------------------------------
`default_nettype none

package vgd_pkg;

    // Item field widths.
    localparam int COORD_W    = 32;
    localparam int INV_W      = 24;
    localparam int FRAC_OUT   = 24;
    localparam int INDEX_BITS = 20;
    localparam int KEY_W      = 3 * INDEX_BITS;
    localparam int ENTRY_W    = KEY_W + 1;

    // Voxel table geometry; the entry count is a power of two.
    localparam int TABLE_ENTRIES = 4096;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int MAX_PROBES    = 8;
    localparam int PROBE_W       = $clog2(MAX_PROBES + 1);

    // Coordinate times reciprocal voxel size, and its floored integer part.
    localparam int PROD_W = COORD_W + INV_W + 1;
    localparam int Q_W    = PROD_W - FRAC_OUT;

    localparam int IDX_MAX = 2 ** (INDEX_BITS - 1) - 1;
    localparam int IDX_MIN = -(2 ** (INDEX_BITS - 1));

    // Spatial hash primes.
    localparam logic [31:0] PRIME_X = 32'd73856093;
    localparam logic [31:0] PRIME_Y = 32'd19349663;
    localparam logic [31:0] PRIME_Z = 32'd83492791;

    // Configuration port.
    localparam int               APB_DATA_W = 32;
    localparam int               APB_ADDR_W = 3;
    localparam logic             REG_IDX_INV = 1'b0;
    localparam logic [INV_W-1:0] INV_RESET   = 24'd65536;

    typedef enum logic [1:0] {
        STAT_DUP     = 2'd0,
        STAT_NEW     = 2'd1,
        STAT_OVF     = 2'd2,
        STAT_CLEARED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
    } t_in_item;

    typedef struct packed {
        t_status                   status;
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
    } t_out_item;

    // Key unit result: pulse plus packed key and home slot.
    typedef struct packed {
        logic              done;
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] slot;
    } t_key_res;

    // Command from the top level to the table controller.
    typedef struct packed {
        logic launch;
        logic clear;
    } t_cmd;

    // Finished classification from the table controller.
    typedef struct packed {
        logic    valid;
        t_status status;
    } t_probe_res;

endpackage

`default_nettype wire

// ===== hdl/vgd_ram.sv =====
// ----------------------------------------------------------------------------
// vgd_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/vgd_key_unit.sv =====
// ----------------------------------------------------------------------------
// vgd_key_unit
// Voxel index and spatial hash, one coordinate per cycle on a shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module vgd_key_unit
    import vgd_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic        [INV_W-1:0]   i_inv,
    input  wire logic signed [COORD_W-1:0] i_x,
    input  wire logic signed [COORD_W-1:0] i_y,
    input  wire logic signed [COORD_W-1:0] i_z,
    output t_key_res                       o_key
);

    logic                     r_run;
    logic [1:0]               r_phase;
    logic                     r_done;
    logic signed [PROD_W-1:0] r_prod;
    logic [KEY_W-1:0]         r_key;
    logic [ADDR_W-1:0]        r_hash;

    logic signed [COORD_W-1:0]  w_coord;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [Q_W-1:0]      w_q;
    logic signed [Q_W-1:0]      w_sat;
    logic [ADDR_W-1:0]          w_prime;
    logic [2*ADDR_W-1:0]        w_hmul;

    // Phase n multiplies coordinate n; phase n+1 floors and hashes it.
    always_comb begin
        case (r_phase)
            2'd0:    w_coord = i_x;
            2'd1:    w_coord = i_y;
            default: w_coord = i_z;
        endcase
        case (r_phase)
            2'd1:    w_prime = PRIME_X[ADDR_W-1:0];
            2'd2:    w_prime = PRIME_Y[ADDR_W-1:0];
            default: w_prime = PRIME_Z[ADDR_W-1:0];
        endcase
    end

    assign w_prod = w_coord * $signed({1'b0, i_inv});

    // An arithmetic shift of the product floors toward minus infinity.
    assign w_q = r_prod[PROD_W-1:FRAC_OUT];

    always_comb begin
        if (w_q > Q_W'(IDX_MAX)) begin
            w_sat = Q_W'(IDX_MAX);
        end else if (w_q < Q_W'(IDX_MIN)) begin
            w_sat = Q_W'(IDX_MIN);
        end else begin
            w_sat = w_q;
        end
    end

    // Only the low address bits of each prime product reach the slot.
    assign w_hmul = (2*ADDR_W)'(w_sat[ADDR_W-1:0]) * (2*ADDR_W)'(w_prime);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_phase <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= r_run && (r_phase == 2'd3);
            if (i_start) begin
                r_run   <= 1'b1;
                r_phase <= 2'd0;
            end else if (r_run) begin
                r_phase <= r_phase + 2'd1;
                if (r_phase == 2'd3) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hash <= '0;
            r_key  <= '0;
        end else if (r_run) begin
            r_prod <= w_prod;
            if (r_phase != 2'd0) begin
                r_hash <= r_hash ^ w_hmul[ADDR_W-1:0];
                r_key  <= {w_sat[INDEX_BITS-1:0], r_key[KEY_W-1:INDEX_BITS]};
            end
        end
    end

    assign o_key.done = r_done;
    assign o_key.key  = r_key;
    assign o_key.slot = r_hash;

endmodule

`default_nettype wire

// ===== hdl/vgd_table_ctrl.sv =====
// ----------------------------------------------------------------------------
// vgd_table_ctrl
// Voxel key table with linear probe sequencer and clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module vgd_table_ctrl
    import vgd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cmd     i_cmd,
    input  wire t_key_res i_key,
    output logic          o_busy,
    output t_probe_res    o_res
);

    t_state             r_state;
    t_state             n_state;
    logic [ADDR_W-1:0]  r_slot;
    logic [KEY_W-1:0]   r_key;
    logic [PROBE_W-1:0] r_probe;
    logic [ADDR_W-1:0]  r_clr_addr;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic               w_re;
    logic [ENTRY_W-1:0] w_rdata;

    logic w_free;
    logic w_match;
    logic w_last_probe;
    logic w_clr_last;

    // Entry layout: valid flag above the packed key.
    assign w_free       = !w_rdata[KEY_W];
    assign w_match      = (w_rdata[KEY_W-1:0] == r_key);
    assign w_last_probe = (r_probe == PROBE_W'(MAX_PROBES - 1));
    assign w_clr_last   = (r_clr_addr == ADDR_W'(TABLE_ENTRIES - 1));

    vgd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (w_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd.launch) begin
                    n_state = i_cmd.clear ? ST_CLEAR : ST_HASH;
                end
            end
            ST_HASH: begin
                if (i_key.done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_free || w_match || w_last_probe) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_we         = 1'b0;
        w_waddr      = r_clr_addr;
        w_wdata      = '0;
        w_re         = 1'b0;
        o_res.valid  = 1'b0;
        o_res.status = STAT_OVF;
        case (r_state)
            ST_INIT: begin
                w_we = 1'b1;
            end
            ST_READ: begin
                w_re = 1'b1;
            end
            ST_CHECK: begin
                if (w_free) begin
                    w_we         = 1'b1;
                    w_waddr      = r_slot;
                    w_wdata      = {1'b1, r_key};
                    o_res.valid  = 1'b1;
                    o_res.status = STAT_NEW;
                end else if (w_match) begin
                    o_res.valid  = 1'b1;
                    o_res.status = STAT_DUP;
                end else if (w_last_probe) begin
                    o_res.valid  = 1'b1;
                    o_res.status = STAT_OVF;
                end
            end
            ST_CLEAR: begin
                w_we = 1'b1;
                if (w_clr_last) begin
                    o_res.valid  = 1'b1;
                    o_res.status = STAT_CLEARED;
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_INIT || r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end else begin
                r_clr_addr <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_HASH && i_key.done) begin
            r_slot  <= i_key.slot;
            r_key   <= i_key.key;
            r_probe <= '0;
        end else if (r_state == ST_CHECK) begin
            r_slot  <= r_slot + ADDR_W'(1);
            r_probe <= r_probe + PROBE_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/voxel_grid_point_dedup_top.sv =====
// ----------------------------------------------------------------------------
// voxel_grid_point_dedup_top
// A point's result strobes after the key unit has hashed its three
// coordinates and the first probed slot decides it; each further slot adds a
// read and a compare, up to MAX_PROBES slots. One point is taken at a time,
// serialised by the coordinate multiplier and the read-compare loop; a clear
// item sweeps every table entry. Reset is synchronous; busy stays high while
// the table is swept empty. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_grid_point_dedup_top
    import vgd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Command channel.
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_in_item              i_req,
    // Result channel.
    output logic                       o_res_valid,
    output t_out_item                  o_res,
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // The item is accepted when start meets an idle block. The item is held
    // in r_req for the whole time it is processed, so the key unit can read
    // its coordinates one per cycle.
    logic       w_accept;
    t_in_item   r_req;
    logic       r_res_valid;
    t_out_item  r_res;
    logic [INV_W-1:0] r_inv;

    logic       w_cfg_wr;
    logic       w_cfg_idx;
    t_cmd       w_cmd;
    t_key_res   w_key;
    t_probe_res w_probe;
    logic       w_busy;

    assign w_accept = start && !w_busy;
    assign busy     = w_busy;

    // Configuration: one register at byte addresses 0 to 3. The port never
    // waits. Writes to addresses 4 to 7 are ignored and read back as zero.
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[2];
    assign w_cfg_wr  = psel && penable && pwrite && (w_cfg_idx == REG_IDX_INV);
    assign prdata    = (w_cfg_idx == REG_IDX_INV) ?
                       {{(APB_DATA_W - INV_W){1'b0}}, r_inv} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= INV_RESET;
        end else if (w_cfg_wr) begin
            r_inv <= pwdata[INV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
    end

    // The key unit only runs for point items; the controller sees every
    // accepted item and chooses between probing and the clearing sweep.
    assign w_cmd.launch = w_accept;
    assign w_cmd.clear  = i_req.req_type;

    vgd_key_unit u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && !i_req.req_type),
        .i_inv   (r_inv),
        .i_x     (r_req.x_coord),
        .i_y     (r_req.y_coord),
        .i_z     (r_req.z_coord),
        .o_key   (w_key)
    );

    vgd_table_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_key   (w_key),
        .o_busy  (w_busy),
        .o_res   (w_probe)
    );

    // Output register. It is loaded in the cycle the controller goes idle,
    // so a new item can already be accepted while the result is shown.
    // A clear result carries zero coordinates; a point echoes its own.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= w_probe.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_probe.valid) begin
            r_res.status <= w_probe.status;
            if (w_probe.status == STAT_CLEARED) begin
                r_res.out_x <= '0;
                r_res.out_y <= '0;
                r_res.out_z <= '0;
            end else begin
                r_res.out_x <= r_req.x_coord;
                r_res.out_y <= r_req.y_coord;
                r_res.out_z <= r_req.z_coord;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Every accepted item keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("block idle right after accepting an item");

    // Two results never come in consecutive cycles.
    a_res_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("two results in consecutive cycles");

    // A result only follows a cycle in which an item was in progress.
    a_res_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(w_busy))
        else $error("result without an item in progress");

    // A clear result carries zero coordinates.
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == STAT_CLEARED) |->
        (o_res.out_x == '0 && o_res.out_y == '0 && o_res.out_z == '0))
        else $error("clear result with nonzero coordinates");

endmodule

`default_nettype wire
